// ----- hdl/rtm_pkg.sv -----
// rtm_pkg: shared types, constants and the ring weight function for the
// ring template matcher. No dependencies.
`default_nettype none
package rtm_pkg;

    localparam int MAX_WINDOW_DEF = 31;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CELL_VALUE_W = 15;
    localparam int CENTRE_W     = 10;
    localparam int SCORE_W      = 15;
    localparam int WEIGHT_W     = 5;
    localparam int PART_W       = 8;
    localparam int COL_SUM_W    = 11;
    localparam int GRP_SUM_W    = 14;

    localparam logic [2:0] REG_GRID_WIDTH      = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_WINDOW_SIZE     = 3'd2;
    localparam logic [2:0] REG_RING_RADIUS_SQ  = 3'd3;
    localparam logic [2:0] REG_OCCUPIED_LIMIT  = 3'd4;
    localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd5;

    localparam logic [10:0] GRID_WIDTH_RST      = 11'd1024;
    localparam logic [10:0] GRID_HEIGHT_RST     = 11'd1024;
    localparam logic [4:0]  WINDOW_SIZE_RST     = 5'd5;
    localparam logic [15:0] RING_RADIUS_SQ_RST  = 16'd64;
    localparam logic [14:0] OCCUPIED_LIMIT_RST  = 15'd16384;
    localparam logic [13:0] SCORE_THRESHOLD_RST = 14'd31;

    typedef struct packed {
        logic                shift;
        logic                cap_part;
        logic                cap_sum;
        logic [4:0]          half;
        logic [15:0]         ring_sq;
    } cell_ctl_t;

    typedef struct packed {
        logic                hit;
        logic [CENTRE_W-1:0] cx;
        logic [CENTRE_W-1:0] cy;
    } meta_t;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [CENTRE_W-1:0] cy;
        logic [CENTRE_W-1:0] cx;
    } result_t;

    // weight in tenths for column age a and row offset d, 0 outside the window
    function automatic logic signed [WEIGHT_W-1:0] ring_weight(
        input logic [4:0]  half,
        input logic [15:0] ring_sq,
        input int          a,
        input int          d
    );
        int kk;
        int dx;
        int dy;
        int e;
        kk = 2 * int'(half);
        dx = int'(half) - a;
        dy = int'(half) - d;
        e  = 16 * (dx * dx + dy * dy) - int'(ring_sq);
        if (e < 0)
            e = -e;
        if (a > kk || d > kk)
            return 5'sd0;
        else if (e <= 32)
            return 5'sd10;
        else if (e <= 56)
            return 5'sd8;
        else if (e <= 64)
            return 5'sd5;
        else
            return -5'sd1;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rtm_ram.sv -----
// rtm_ram: generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module rtm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/rtm_cell.sv -----
// rtm_cell: one window column of the ring template matcher; holds the column
// bits and its weights, and scores the column. Depends on rtm_pkg.
`default_nettype none
module rtm_cell #(
    parameter int MAX_WINDOW = 31,
    parameter int AGE        = 0
) (
    input  wire                                 clk,
    input  rtm_pkg::cell_ctl_t                  ctl,
    input  wire  [MAX_WINDOW-1:0]               col_in,
    output logic [MAX_WINDOW-1:0]               col_out,
    output logic signed [rtm_pkg::COL_SUM_W-1:0] col_sum
);
    import rtm_pkg::*;

    localparam int NG = (MAX_WINDOW + 7) / 8;

    logic [MAX_WINDOW-1:0]             col_reg;
    logic signed [WEIGHT_W-1:0]        weight_reg [MAX_WINDOW];
    logic signed [PART_W-1:0]          part_next  [NG];
    logic signed [PART_W-1:0]          part_reg   [NG];
    logic signed [COL_SUM_W-1:0]       sum_next;
    logic signed [COL_SUM_W-1:0]       sum_reg;

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < MAX_WINDOW; d++)
            weight_reg[d] <= ring_weight(ctl.half, ctl.ring_sq, AGE, d);
        if (ctl.shift)
            col_reg <= col_in;
        if (ctl.cap_part)
            part_reg <= part_next;
        if (ctl.cap_sum)
            sum_reg <= sum_next;
    end

    always_comb
    begin
        int d;
        for (int g = 0; g < NG; g++)
        begin
            part_next[g] = '0;
            for (int i = 0; i < 8; i++)
            begin
                d = g * 8 + i;
                if (d < MAX_WINDOW && col_reg[d])
                    part_next[g] = part_next[g] + PART_W'(weight_reg[d]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < NG; g++)
            sum_next = sum_next + COL_SUM_W'(part_reg[g]);
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;
endmodule
`default_nettype wire

// ----- hdl/ring_template_match_unit.sv -----
// ring_template_match_unit: top level of the ring template matcher.
// Depends on rtm_pkg, rtm_ram and rtm_cell.
//
// Takes one grid cell per cycle in raster order while the output queue has room,
// and gives a result for each cell that completes a window whose score beats
// the threshold. The rate of one cell per clock while not stalled is set by the
// line store: one read and one write of a column word per cell. Occupancy bits
// of earlier rows sit
// in the line store as one word per column; a row of column cells holds the
// window, each cell scoring its own column, and a registered adder tree sums
// the columns. A two-entry output queue lets input run on while a result
// waits. The line store needs no clearing pass after reset.
`default_nettype none
module ring_template_match_unit #(
    parameter int MAX_WINDOW = rtm_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = rtm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rtm_pkg::MAX_HEIGHT_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,  // [14:0] cell_value
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata   // [9:0] centre_x, [19:10] centre_y, [34:20] score
);
    import rtm_pkg::*;

    localparam int RW = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int CH = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int NT = (MAX_WINDOW + 7) / 8;

    // configuration registers
    logic [10:0] grid_width_reg;
    logic [10:0] grid_height_reg;
    logic [4:0]  window_size_reg;
    logic [15:0] ring_radius_sq_reg;
    logic [14:0] occupied_limit_reg;
    logic [13:0] score_threshold_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg      <= GRID_WIDTH_RST;
            grid_height_reg     <= GRID_HEIGHT_RST;
            window_size_reg     <= WINDOW_SIZE_RST;
            ring_radius_sq_reg  <= RING_RADIUS_SQ_RST;
            occupied_limit_reg  <= OCCUPIED_LIMIT_RST;
            score_threshold_reg <= SCORE_THRESHOLD_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_GRID_WIDTH:      grid_width_reg      <= pwdata[10:0];
                REG_GRID_HEIGHT:     grid_height_reg     <= pwdata[10:0];
                REG_WINDOW_SIZE:     window_size_reg     <= pwdata[4:0];
                REG_RING_RADIUS_SQ:  ring_radius_sq_reg  <= pwdata[15:0];
                REG_OCCUPIED_LIMIT:  occupied_limit_reg  <= pwdata[14:0];
                REG_SCORE_THRESHOLD: score_threshold_reg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_GRID_WIDTH:      prdata = 32'(grid_width_reg);
            REG_GRID_HEIGHT:     prdata = 32'(grid_height_reg);
            REG_WINDOW_SIZE:     prdata = 32'(window_size_reg);
            REG_RING_RADIUS_SQ:  prdata = 32'(ring_radius_sq_reg);
            REG_OCCUPIED_LIMIT:  prdata = 32'(occupied_limit_reg);
            REG_SCORE_THRESHOLD: prdata = 32'(score_threshold_reg);
            default:             prdata = '0;
        endcase
    end

    // effective limits
    logic [LW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [5:0]    k_eff;
    logic [4:0]    half;

    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = LW'(1);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            w_eff = LW'(MAX_WIDTH);
        else
            w_eff = LW'(grid_width_reg);
        if (grid_height_reg == '0)
            h_eff = HW'(1);
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(grid_height_reg);
        k_eff = {1'b0, window_size_reg | 5'd1};
        if (32'(k_eff) > 32'(MAX_WINDOW))
            k_eff = 6'((MAX_WINDOW - 1) | 1);
        half = k_eff[5:1];
    end

    // pipeline control
    logic        en;
    logic        accept;
    logic [6:1]  vld_reg;
    meta_t       meta_reg [1:6];

    assign s_tready = en;
    assign accept   = s_tvalid & en;

    // raster position
    logic [CW-1:0] col_reg;
    logic [CH-1:0] row_reg;
    logic [CW-1:0] col_next;
    logic [CH-1:0] row_next;
    logic [CW-1:0] x;
    logic [CH-1:0] y;
    logic [CH:0]   row_inc;
    logic [CW:0]   x_inc;
    logic [CH:0]   y_inc;
    logic          occ;
    meta_t         meta_in;

    always_comb
    begin
        if (LW'(col_reg) >= w_eff)
        begin
            x       = '0;
            row_inc = {1'b0, row_reg} + 1'b1;
        end
        else
        begin
            x       = col_reg;
            row_inc = {1'b0, row_reg};
        end
        if (HW'(row_inc) >= h_eff || row_inc[CH])
            y = '0;
        else
            y = row_inc[CH-1:0];
        x_inc = {1'b0, x} + 1'b1;
        y_inc = {1'b0, y} + 1'b1;
        if (LW'(x_inc) >= w_eff)
        begin
            col_next = '0;
            if (HW'(y_inc) >= h_eff)
                row_next = '0;
            else
                row_next = y_inc[CH-1:0];
        end
        else
        begin
            col_next = x_inc[CW-1:0];
            row_next = y;
        end
        occ         = (s_tdata[14:0] != '0) && (s_tdata[14:0] < occupied_limit_reg);
        meta_in.hit = (16'(x) + 16'd1 >= 16'(k_eff)) && (16'(y) + 16'd1 >= 16'(k_eff));
        meta_in.cx  = CENTRE_W'(16'(x) - 16'(half));
        meta_in.cy  = CENTRE_W'(16'(y) - 16'(half));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            vld_reg <= '0;
        end
        else if (en)
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            vld_reg <= {vld_reg[5:1], accept};
        end
    end

    // line store: one word per column, bit d-1 holds row y-d
    logic [CW-1:0]   s1_x_reg;
    logic            s1_occ_reg;
    logic            byp_hit_reg;
    logic [RW-1:0]   byp_data_reg;
    logic [RW-1:0]   ram_rdata;
    logic [RW-1:0]   col_word;
    logic [RW:0]     col_full;
    logic            ram_we;

    assign ram_we   = vld_reg[1] & en;
    assign col_word = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign col_full = {col_word, s1_occ_reg};

    rtm_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_x_reg),
        .wdata (col_full[RW-1:0]),
        .re    (accept),
        .raddr (x),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= x;
            s1_occ_reg   <= occ;
            meta_reg[1]  <= meta_in;
            byp_hit_reg  <= vld_reg[1] && (s1_x_reg == x);
            byp_data_reg <= col_full[RW-1:0];
        end
        if (en)
        begin
            for (int i = 2; i <= 6; i++)
                meta_reg[i] <= meta_reg[i-1];
        end
    end

    // window cells
    cell_ctl_t                   ctl;
    logic [MAX_WINDOW-1:0]       col_link [MAX_WINDOW+1];
    logic signed [COL_SUM_W-1:0] col_sum  [MAX_WINDOW];

    assign ctl.shift    = vld_reg[1] & en;
    assign ctl.cap_part = vld_reg[2] & en;
    assign ctl.cap_sum  = vld_reg[3] & en;
    assign ctl.half     = half;
    assign ctl.ring_sq  = ring_radius_sq_reg;
    assign col_link[0]  = col_full[MAX_WINDOW-1:0];

    for (genvar a = 0; a < MAX_WINDOW; a++)
    begin : g_cell
        rtm_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .AGE        (a)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .col_in  (col_link[a]),
            .col_out (col_link[a+1]),
            .col_sum (col_sum[a])
        );
    end

    // adder tree over the columns
    logic signed [GRP_SUM_W-1:0] grp_next [NT];
    logic signed [GRP_SUM_W-1:0] grp_reg  [NT];
    logic signed [SCORE_W-1:0]   score_next;
    logic signed [SCORE_W-1:0]   score_reg;
    logic                        report;

    always_comb
    begin
        int a;
        for (int t = 0; t < NT; t++)
        begin
            grp_next[t] = '0;
            for (int i = 0; i < 8; i++)
            begin
                a = t * 8 + i;
                if (a < MAX_WINDOW)
                    grp_next[t] = grp_next[t] + GRP_SUM_W'(col_sum[a]);
            end
        end
    end

    always_comb
    begin
        score_next = '0;
        for (int t = 0; t < NT; t++)
            score_next = score_next + SCORE_W'(grp_reg[t]);
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[4] & en)
            grp_reg <= grp_next;
        if (vld_reg[5] & en)
            score_reg <= score_next;
    end

    assign report = vld_reg[6] & en & meta_reg[6].hit
                  & (score_reg > $signed({1'b0, score_threshold_reg}));

    // output queue
    result_t     fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        pop;

    assign en       = (count_reg != 2'd2);
    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {5'd0, fifo_reg[rd_ptr_reg]};

    always_ff @(posedge clk)
    begin
        if (report)
        begin
            fifo_reg[wr_ptr_reg].score <= score_reg;
            fifo_reg[wr_ptr_reg].cy    <= meta_reg[6].cy;
            fifo_reg[wr_ptr_reg].cx    <= meta_reg[6].cx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (report)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (report && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !report)
                count_reg <= count_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

// ----- bench/ring_template_match_unit_test.sv -----
// Self-checking bench for ring_template_match_unit: a scoreboard class scores
// every accepted cell and checks the centre/score results in order.
// Depends on rtm_pkg and ring_template_match_unit.
`default_nettype none
module ring_template_match_unit_test;
    import rtm_pkg::*;

    localparam int RING_ROWS = 30;
    localparam int WIN_MAX   = 31;
    localparam int WATCHDOG  = 20000;

    typedef struct {
        logic [9:0]  cx;
        logic [9:0]  cy;
        logic [14:0] score;
    } ring_hit_t;

    class ring_scoreboard;
        logic [10:0] grid_width;
        logic [10:0] grid_height;
        logic [4:0]  window_size;
        logic [15:0] ring_sq;
        logic [14:0] occ_limit;
        logic [13:0] thresh;
        bit          line_bits [RING_ROWS][1024];
        bit          win_bits [WIN_MAX][WIN_MAX];
        int          weights [WIN_MAX][WIN_MAX];
        int          col;
        int          row;
        int          errors;
        ring_hit_t   hits_q [$];

        function new();
            grid_width  = GRID_WIDTH_RST;
            grid_height = GRID_HEIGHT_RST;
            window_size = WINDOW_SIZE_RST;
            ring_sq     = RING_RADIUS_SQ_RST;
            occ_limit   = OCCUPIED_LIMIT_RST;
            thresh      = SCORE_THRESHOLD_RST;
            col = 0;
            row = 0;
            errors = 0;
            build_weights();
        endfunction

        function int side();
            int k;
            k = int'(window_size) | 1;
            if (k > WIN_MAX)
                k = (WIN_MAX - 1) | 1;
            return k;
        endfunction

        function int clamp(int v, int mx);
            if (v == 0)
                return 1;
            return (v > mx) ? mx : v;
        endfunction

        function void build_weights();
            int k;
            int h;
            int e;
            k = side();
            h = k / 2;
            for (int i = 0; i < WIN_MAX; i++)
                for (int j = 0; j < WIN_MAX; j++)
                begin
                    e = 16 * ((j - h) * (j - h) + (i - h) * (i - h)) - int'(ring_sq);
                    if (e < 0)
                        e = -e;
                    if (i >= k || j >= k)
                        weights[i][j] = 0;
                    else if (e <= 32)
                        weights[i][j] = 10;
                    else if (e <= 56)
                        weights[i][j] = 8;
                    else if (e <= 64)
                        weights[i][j] = 5;
                    else
                        weights[i][j] = -1;
                end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_GRID_WIDTH:      grid_width  = val[10:0];
                REG_GRID_HEIGHT:     grid_height = val[10:0];
                REG_WINDOW_SIZE:     window_size = val[4:0];
                REG_RING_RADIUS_SQ:  ring_sq     = val[15:0];
                REG_OCCUPIED_LIMIT:  occ_limit   = val[14:0];
                REG_SCORE_THRESHOLD: thresh      = val[13:0];
                default: ;
            endcase
            build_weights();
        endfunction

        function void note_cell(logic [14:0] v);
            bit        occ;
            int        w;
            int        hgt;
            int        k;
            int        slot;
            int        s;
            int        base;
            int        sc;
            ring_hit_t hit;
            occ = (v != 0) && (v < occ_limit);
            w   = clamp(int'(grid_width), 1024);
            hgt = clamp(int'(grid_height), 1024);
            k   = side();
            if (col >= w)
            begin
                col = 0;
                row++;
            end
            if (row >= hgt)
                row = 0;
            slot = row % RING_ROWS;
            for (int r = 0; r < WIN_MAX; r++)
                for (int c = 0; c < WIN_MAX - 1; c++)
                    win_bits[r][c] = win_bits[r][c + 1];
            win_bits[WIN_MAX - 1][WIN_MAX - 1] = occ;
            for (int d = 1; d < WIN_MAX; d++)
            begin
                s = (slot + RING_ROWS - d) % RING_ROWS;
                win_bits[WIN_MAX - 1 - d][WIN_MAX - 1] = line_bits[s][col];
            end
            line_bits[slot][col] = occ;
            if (col + 1 >= k && row + 1 >= k)
            begin
                sc = 0;
                base = WIN_MAX - k;
                for (int r = 0; r < k; r++)
                    for (int c = 0; c < k; c++)
                        if (win_bits[base + r][base + c])
                            sc += weights[r][c];
                if (sc > int'(thresh))
                begin
                    hit.cx    = 10'(col - k / 2);
                    hit.cy    = 10'(row - k / 2);
                    hit.score = 15'(sc);
                    hits_q.insert(hits_q.size(), hit);
                end
            end
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= hgt)
                    row = 0;
            end
        endfunction

        function void check_hit(logic [39:0] d);
            ring_hit_t want;
            if (hits_q.size() == 0)
            begin
                $error("unexpected result %h", d);
                errors++;
                return;
            end
            want = hits_q.pop_front();
            if (d[9:0] !== want.cx)
            begin
                $error("centre_x: expected %0d, got %0d", want.cx, d[9:0]);
                errors++;
            end
            if (d[19:10] !== want.cy)
            begin
                $error("centre_y: expected %0d, got %0d", want.cy, d[19:10]);
                errors++;
            end
            if (d[34:20] !== want.score)
            begin
                $error("score: expected %0d, got %0d", $signed(want.score),
                       $signed(d[34:20]));
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    ring_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet;

    ring_template_match_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_hit(m_tdata);
        if (rst_n && !(m_tvalid && m_tready) && !(s_tvalid && s_tready))
            quiet++;
        else
            quiet = 0;
        if (quiet >= WATCHDOG)
        begin
            $display("ring_template_match_unit: mismatch");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_cell(logic [14:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_cell(v);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.hits_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [14:0] pick_cell(int p_occ, logic [14:0] lim);
        int r;
        r = $urandom_range(99);
        if (r < p_occ && lim > 1)
            return 15'($urandom_range(int'(lim) - 1, 1));
        else if (r < p_occ + 5)
            return 15'd0;
        else if (r < p_occ + 10)
            return 15'h7FFF;
        else if (r < p_occ + 20)
            return lim;
        return 15'($urandom);
    endfunction

    task automatic run_phase(int ph, int w, int h, int k, int rsq, int lim, int thr,
                             int frames);
        int n;
        int p_occ;
        int wv;
        int hv;
        logic [14:0] dvals [5];
        reg_write(REG_GRID_WIDTH, 32'(w));
        reg_write(REG_GRID_HEIGHT, 32'(h));
        reg_write(REG_WINDOW_SIZE, 32'(k));
        reg_write(REG_RING_RADIUS_SQ, 32'(rsq));
        reg_write(REG_OCCUPIED_LIMIT, 32'(lim));
        reg_write(REG_SCORE_THRESHOLD, 32'(thr));
        case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 63; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 38; stall_pct = 38; end
        endcase
        wv = sb.clamp(w, 1024);
        hv = sb.clamp(h, 1024);
        n  = wv * hv;
        dvals = '{15'd0, 15'h7FFF, 15'(lim - 1), 15'(lim), 15'd1};
        for (int f = 0; f < frames; f++)
        begin
            p_occ = $urandom_range(90, 20);
            for (int i = 0; i < n; i++)
            begin
                if (ph == 1 && f == 1 && i == n / 2)
                    drain();
                if (ph == 0)
                    send_cell((i % 7 < 5) ? dvals[i % 5] : 15'($urandom));
                else
                    send_cell(pick_cell(p_occ, 15'(lim)));
            end
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet    = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_phase(0, 5, 5, 5, 64, 16384, 0, 1);
        run_phase(1, 8, 6, 5, 64, 16384, 20, 2);
        run_phase(2, 0, 0, 0, 0, 32767, 0, 20);
        run_phase(3, 20, 1, 1, 0, 200, 5, 1);
        run_phase(4, 12, 10, 4, 100, 30000, 15, 1);
        run_phase(5, 13, 13, 13, 576, 20000, 50, 1);
        run_phase(6, 7, 9, 3, 16, 32767, 9610, 1);
        run_phase(7, 10, 10, 7, 144, 100, 0, 1);
        run_phase(8, 12, 6, 5, 64, 16384, 30, 1);
        run_phase(9, 6, 6, 9, 64, 16384, 0, 1);
        run_phase(10, 1, 20, 1, 0, 8, 0, 1);
        run_phase(11, 9, 9, 5, 65535, 0, 0, 1);
        run_phase(12, 9, 7, 3, 32, 5000, 12, 1);
        if (sb.errors == 0 && sb.hits_q.size() == 0)
            $display("ring_template_match_unit: match");
        else
            $display("ring_template_match_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
